@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/mt_pkg.sv @@
// Package: constants, control types and word functions of the MT19937 generator.
package mt_pkg;

  localparam int STATE_DEPTH  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int WORD_W       = 32;
  localparam int HALF_W       = WORD_W / 2;
  localparam int IDX_W        = $clog2(STATE_DEPTH);

  localparam logic [IDX_W-1:0]  FILL_LAST = IDX_W'(STATE_DEPTH - 1);

  localparam logic [WORD_W-1:0] TW_MATRIX    = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TW_UPPER     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] TW_LOWER     = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] LCG_MUL      = 32'd69069;
  localparam logic [WORD_W-1:0] LCG_INC      = 32'd1;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;

  // Action codes of an input transaction
  localparam logic ACT_DRAW   = 1'b0;
  localparam logic ACT_RESEED = 1'b1;

  // Seeder control and status
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] seed;
  } seed_ctl_t;

  typedef struct packed {
    logic              push;
    logic              last;
    logic [WORD_W-1:0] word;
  } seed_stat_t;

  // Recompute one state word from its own old value, its successor and the far tap.
  function automatic logic [WORD_W-1:0] twist_word(
    input logic [WORD_W-1:0] w_cur,
    input logic [WORD_W-1:0] w_next,
    input logic [WORD_W-1:0] w_far
  );
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    y = (w_cur & TW_UPPER) | (w_next & TW_LOWER);
    v = w_far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TW_MATRIX;
    end
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ rtl/core/mt_if.sv @@
// Stream interfaces of the generator: command channel and result channel.
interface mt_in_if;
  import mt_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [WORD_W-1:0] seed;

  modport source (output valid, output action, output seed, input ready);
  modport sink   (input valid, input action, input seed, output ready);
endinterface

interface mt_out_if;
  import mt_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

@@ rtl/core/mt_cell.sv @@
// One state cell: holds a word and takes its neighbor's word on a shift.
module mt_cell import mt_pkg::*; (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [WORD_W-1:0] d_in,
  output logic [WORD_W-1:0] q
);

  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= d_in;
    end
  end

  assign q = word_r;

endmodule

@@ rtl/core/mt_seeder.sv @@
// Seed filler: runs the LCG step and emits one state word per two LCG values.
module mt_seeder import mt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  seed_ctl_t  ctl,
  output seed_stat_t stat
);

  logic              busy_r;
  logic              phase_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [WORD_W-1:0] lcg_r;
  logic [HALF_W-1:0] hi_r;
  logic [WORD_W-1:0] lcg_nxt;

  // Low 32 bits of the product only
  assign lcg_nxt = lcg_r * LCG_MUL + LCG_INC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else if (ctl.start) begin
      busy_r  <= 1'b1;
      phase_r <= 1'b0;
      cnt_r   <= '0;
      lcg_r   <= ctl.seed;
    end else if (busy_r) begin
      phase_r <= ~phase_r;
      lcg_r   <= lcg_nxt;
      if (!phase_r) begin
        hi_r <= lcg_r[WORD_W-1:HALF_W];
      end else begin
        cnt_r <= cnt_r + IDX_W'(1);
        if (cnt_r == FILL_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.push = busy_r && phase_r;
  assign stat.last = busy_r && phase_r && (cnt_r == FILL_LAST);
  assign stat.word = {hi_r, lcg_r[WORD_W-1:HALF_W]};

endmodule

@@ rtl/core/mt19937_word_generator_core.sv @@
// MT19937 word generator core: a 624-cell shifting state with on-the-fly twist and tempering.
//
// The 624 state words sit in a row of cells that shift toward cell 0 by one place whenever a
// word enters at cell 623. A draw transaction twists the word in cell 0 against cells 1 and 397,
// pushes the new word in at the tail and returns its tempered value through a registered output.
// The next transaction is taken in the following cycle only if the result is taken in that same
// cycle; a result that waits holds the input closed until it is taken. A reseed transaction walks
// the whole row: the seeder produces each word from the high halves of two LCG values through its
// single 32x32 multiplier, so a reseed keeps the input closed until the row is full and returns no
// result. A draw that arrives before any reseed first fills the row from seed 4357 and then draws.
// No clearing pass follows reset; the first transaction, draw or reseed, seeds the state itself.
`include "assert_macros.svh"

module mt19937_word_generator_core import mt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  mt_in_if.sink    in_ch,
  mt_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_DRAW
  } state_t;

  state_t            state_r;
  logic              seeded_r;
  logic              pending_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;

  seed_ctl_t         seed_ctl;
  seed_stat_t        seed_stat;

  logic              in_fire;
  logic              out_free;
  logic              draw_fire;
  logic              shift_en;
  logic [WORD_W-1:0] twisted;
  logic [WORD_W-1:0] head_word;
  logic [WORD_W-1:0] tap [STATE_DEPTH];

  // Result register may be refilled when empty or emptied this cycle
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Draw now when seeded; else after the fill, once the result register is free
  assign draw_fire = (in_fire && (in_ch.action == ACT_DRAW) && seeded_r) ||
                     ((state_r == S_DRAW) && out_free);

  // Start the seeder on a reseed, or on a draw into an unseeded generator
  assign seed_ctl.start = in_fire && ((in_ch.action == ACT_RESEED) || !seeded_r);
  assign seed_ctl.seed  = (in_ch.action == ACT_RESEED) ? in_ch.seed : DEFAULT_SEED;

  mt_seeder u_seeder (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (seed_ctl),
    .stat  (seed_stat)
  );

  // Cell 0 holds the next word due for twisting; cell 1 its successor, cell 397 the far tap.
  // Cells toward the tail hold words already rewritten this round, as in the in-place twist.
  assign twisted   = twist_word(tap[0], tap[1], tap[TWIST_OFFSET]);
  assign head_word = seed_stat.push ? seed_stat.word : twisted;
  assign shift_en  = draw_fire || seed_stat.push;

  for (genvar gi = 0; gi < STATE_DEPTH; gi++) begin : gen_row
    if (gi == STATE_DEPTH - 1) begin : gen_tail
      mt_cell u_word (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (head_word),
        .q        (tap[gi])
      );
    end else begin : gen_body
      mt_cell u_word (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (tap[gi+1]),
        .q        (tap[gi])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seeded_r    <= 1'b0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Hold the result until taken; refill on a draw
      if (draw_fire) begin
        out_valid_r <= 1'b1;
        out_word_r  <= temper(twisted);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (seed_stat.last) begin
        seeded_r <= 1'b1;
      end

      case (state_r)
        S_IDLE: begin
          if (seed_ctl.start) begin
            pending_r <= (in_ch.action == ACT_DRAW);
            state_r   <= S_FILL;
          end
        end
        S_FILL: begin
          if (seed_stat.last) begin
            state_r <= pending_r ? S_DRAW : S_IDLE;
          end
        end
        S_DRAW: begin
          if (out_free) begin
            pending_r <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_word = out_word_r;

  // Seeder words enter only during a fill, and never collide with a draw shift
  `MT_ASSERT_IMP(a_push_in_fill, seed_stat.push, state_r == S_FILL)
  `MT_ASSERT_IMP(a_no_shift_clash, draw_fire, !seed_stat.push)
  // A draw always leaves a result behind
  `MT_ASSERT_NEXT(a_draw_shows, draw_fire, out_valid_r)
  // The last seed word marks the state seeded and ends the fill
  `MT_ASSERT_NEXT(a_fill_seeds, seed_stat.last, seeded_r && (state_r != S_FILL))

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the MT19937 word generator core: directed table, then random runs.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mt_pkg::*;

  // Total input transactions, directed table included.
  localparam int ITEM_TARGET = 1450;
  // Trailing wait that covers the fill of a reseed or a first unseeded draw.
  localparam int SEED_CYCLES = 1300;
  // Generous ceiling on the simulated cycles.
  localparam int CYCLE_LIMIT = 10_000_000;
  // Word index value that marks a generator that has never been seeded.
  localparam int UNSEEDED = STATE_DEPTH + 1;

  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] seed;
  } gen_cmd_t;

  // Directed stimulus. No row carries a fixed expected word: every output of this
  // generator takes a full seed fill and twist to work out, so the predictor checks all.
  localparam int DIRECTED_ROWS = 18;
  localparam gen_cmd_t DIRECTED_CMDS [DIRECTED_ROWS] = '{
    '{ACT_DRAW,   32'h0000_0000},  // draw on an unseeded generator: self-seed with 4357
    '{ACT_DRAW,   32'hffff_ffff},  // seed field is ignored on a draw
    '{ACT_DRAW,   32'h0000_0000},
    '{ACT_RESEED, 32'h0000_0000},  // lowest seed
    '{ACT_DRAW,   32'h1234_5678},  // first draw after a reseed twists the whole state
    '{ACT_DRAW,   32'h0000_0000},
    '{ACT_RESEED, 32'hffff_ffff},  // highest seed
    '{ACT_DRAW,   32'h0000_0000},
    '{ACT_DRAW,   32'hffff_ffff},
    '{ACT_RESEED, 32'd4357},       // explicit default seed
    '{ACT_DRAW,   32'h0000_0000},
    '{ACT_RESEED, 32'h0000_0001},  // reseed straight after reseed: the first is discarded
    '{ACT_RESEED, 32'h8000_0000},
    '{ACT_DRAW,   32'h0000_0000},
    '{ACT_RESEED, 32'h7fff_ffff},
    '{ACT_DRAW,   32'h5555_5555},
    '{ACT_RESEED, 32'haaaa_aaaa},
    '{ACT_DRAW,   32'haaaa_aaaa}
  };

  logic clk;
  logic rst_n;

  mt_in_if  in_ch ();
  mt_out_if out_ch ();

  mt19937_word_generator_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: its own copy of the 624-word table and the read position.
  logic [WORD_W-1:0] gen_table [STATE_DEPTH];
  int unsigned       gen_pos;

  logic [WORD_W-1:0] pending_words [$];
  int                items_sent;
  int                words_checked;
  int                error_count;
  int                cycle_count;
  logic              hold_on;

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count == CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d words still pending", cycle_count,
             pending_words.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // Fill the table from a seed: each word takes the high halves of two LCG steps.
  function automatic void fill_table(input logic [WORD_W-1:0] seed_val);
    logic [WORD_W-1:0] s;
    logic [HALF_W-1:0] upper_half;
    s = seed_val;
    for (int i = 0; i < STATE_DEPTH; i++) begin
      upper_half = s[WORD_W-1:HALF_W];
      s = s * LCG_MUL + LCG_INC;
      gen_table[i] = {upper_half, s[WORD_W-1:HALF_W]};
      s = s * LCG_MUL + LCG_INC;
    end
    gen_pos = STATE_DEPTH;
  endfunction

  // Regenerate all words in place, in ascending order, so later words see new ones.
  function automatic void twist_table();
    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] fresh;
    for (int k = 0; k < STATE_DEPTH; k++) begin
      mixed = {gen_table[k][WORD_W-1], gen_table[(k + 1) % STATE_DEPTH][WORD_W-2:0]};
      fresh = gen_table[(k + TWIST_OFFSET) % STATE_DEPTH] ^ {1'b0, mixed[WORD_W-1:1]};
      gen_table[k] = mixed[0] ? (fresh ^ TW_MATRIX) : fresh;
    end
    gen_pos = 0;
  endfunction

  // Work out the tempered word that the next draw returns and advance the position.
  function automatic logic [WORD_W-1:0] next_tempered_word();
    logic [WORD_W-1:0] t;
    if (gen_pos >= STATE_DEPTH) begin
      if (gen_pos != STATE_DEPTH) begin
        fill_table(DEFAULT_SEED);
      end
      twist_table();
    end
    t = gen_table[gen_pos];
    gen_pos++;
    t = t ^ {11'd0, t[WORD_W-1:11]};
    t = t ^ ({t[WORD_W-8:0], 7'd0} & TEMPER_B);
    t = t ^ ({t[WORD_W-16:0], 15'd0} & TEMPER_C);
    t = t ^ {18'd0, t[WORD_W-1:18]};
    return t;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("[%0t] MISMATCH %s: got %08h want %08h (word %0d)", $realtime, what, got,
             want, words_checked);
    error_count++;
  endtask

  // Compare one returned word against the oldest pending prediction.
  task automatic check_word(input logic [WORD_W-1:0] got);
    logic [WORD_W-1:0] want;
    if (pending_words.size() == 0) begin
      report_mismatch("unexpected random_word", got, '0);
    end else begin
      want = pending_words.pop_front();
      if (got !== want) begin
        report_mismatch("random_word", got, want);
      end
    end
    words_checked++;
  endtask

  // Neither side inserts random idle cycles while this window of results goes by.
  function automatic bit quiet_window();
    return words_checked >= 300 && words_checked < 700;
  endfunction

  // ---------------------------------------------------------------- result side

  // Sample the handshake on the pre-edge values, then choose ready for the next cycle.
  initial begin
    words_checked = 0;
    error_count   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        check_word(out_ch.random_word);
      end
      if (hold_on) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet_window() || ($urandom_range(99) >= 6);
      end
    end
  end

  // Hold the result side off for a long stretch once, while the sender keeps going, so
  // the output register fills and the block closes its input.
  initial begin
    hold_on = 1'b0;
    wait (words_checked >= 150);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (500) @(posedge clk);
    hold_on = 1'b0;
  end

  // ---------------------------------------------------------------- command side

  // Offer one transaction, with a random idle gap in front, and predict on acceptance.
  task automatic offer(input logic act, input logic [WORD_W-1:0] seed_val);
    while (!quiet_window() && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.seed   <= seed_val;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    if (act == ACT_RESEED) begin
      fill_table(seed_val);
    end else begin
      pending_words.push_back(next_tempered_word());
    end
    items_sent++;
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_words.size() != 0);
  endtask

  function automatic logic [WORD_W-1:0] pick_seed();
    case ($urandom_range(7))
      0:       return WORD_W'($urandom_range(15));
      1:       return ~WORD_W'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int       seg;
    int       run_len;
    bit       long_run;

    gen_pos    = UNSEEDED;
    items_sent = 0;
    for (int i = 0; i < STATE_DEPTH; i++) begin
      gen_table[i] = '0;
    end

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_DRAW;
    in_ch.seed   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the table, then let everything settle.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      offer(DIRECTED_CMDS[r].action, DIRECTED_CMDS[r].seed);
    end
    drain_results();

    // Random part: runs that start with a reseed (mostly) and continue with draws.
    // Most runs are short; the second run and a few others cross the 624-word
    // boundary so that the twist after a used-up table is exercised too.
    seg = 0;
    while (items_sent < ITEM_TARGET) begin
      if (seg != 0 && $urandom_range(3) == 0) begin
        drain_results();
      end
      long_run = (seg == 1) || ($urandom_range(11) == 0);
      run_len  = long_run ? $urandom_range(720, 630) : $urandom_range(30, 0);
      if ($urandom_range(99) < 85) begin
        offer(ACT_RESEED, pick_seed());
      end
      for (int n = 0; n < run_len && items_sent < ITEM_TARGET; n++) begin
        offer(ACT_DRAW, $urandom);
      end
      seg++;
    end

    // Wait out the last words, then a possible trailing reseed fill.
    drain_results();
    repeat (SEED_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/mt_pkg.sv
rtl/core/mt_if.sv
rtl/core/mt_cell.sv
rtl/core/mt_seeder.sv
rtl/core/mt19937_word_generator_core.sv
test/testbench.sv
